// File: sv/rmq_pkg.sv
// shared constants and types for the rotation matrix to quaternion converter
// no dependencies
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W        = 16;   // width of a matrix element or a component
  localparam int MAG_W         = 17;   // width of a signed sum or difference of two elements

  // output slot of a component
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_t;

endpackage

`default_nettype wire

// File: sv/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion converter, Shepperd's method in fixed point
// depends on rmq_pkg, rmq_sqrt and rmq_div
//
//  channel | dir | ports                           | content
//  in_     | in  | tvalid tready tdata[143:0]      | nine matrix elements
//  out_    | out | tvalid tready tdata[63:0] tuser | quaternion, degenerate flag
//
// one transaction enters per cycle while the output is not stalled; the
// pipeline depth is set by the bit-per-stage square root and the
// bit-per-stage dividers
// reset (rst_n low, synchronous) clears the valid bits of every stage
// when the output register holds a transaction that is not taken, the whole
// pipeline holds and in_tready is low
`default_nettype none

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0 r2c1 r2c2, 16 bits each
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // quat_x quat_y quat_z quat_w, 16 bits each
  output logic [63:0]       out_tdata,
  // degenerate
  output logic              out_tuser
);

  localparam int BIGW = (FRAC_BITS > 17) ? FRAC_BITS : 17;
  localparam int RADW = BIGW + 2;
  localparam int VW0  = RADW + FRAC_BITS;
  localparam int VW   = VW0 + (VW0 % 2);
  localparam int RTW  = VW / 2;
  localparam int NW   = MAG_W + FRAC_BITS + 1;
  localparam int DW   = RTW + 1;
  localparam int SW   = ELEM_W + 2;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint LIM = (ONE > 32767) ? 32767 : ONE;

  typedef struct packed {
    slot_t                 slot;
    logic                  degen;
    logic [3:0][MAG_W-1:0] num;
  } side_a_t;

  typedef struct packed {
    slot_t          slot;
    logic           degen;
    logic [3:0]     neg;
    logic [RTW-1:0] half;
  } side_b_t;

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // stage 1: trace, pivot, element pairs
  logic signed [ELEM_W-1:0] m [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r][c] = in_tdata[(r*3+c)*ELEM_W +: ELEM_W];
      end
    end
  end

  logic                    s1_vld_r;
  logic signed [SW-1:0]    s1_tr_r;
  logic [1:0]              s1_piv_r;
  logic signed [ELEM_W-1:0] s1_dg_r [3];
  logic [MAG_W-1:0]        s1_d12_r, s1_d20_r, s1_d01_r, s1_s01_r, s1_s02_r, s1_s12_r;
  logic [1:0]              piv_nxt;
  logic signed [ELEM_W-1:0] dmax;

  always_comb begin
    piv_nxt = 2'd0;
    dmax    = m[0][0];
    if (m[1][1] > dmax) begin
      piv_nxt = 2'd1;
      dmax    = m[1][1];
    end
    if (m[2][2] > dmax) begin
      piv_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_tr_r  <= SW'(m[0][0]) + SW'(m[1][1]) + SW'(m[2][2]);
      s1_piv_r <= piv_nxt;
      for (int i = 0; i < 3; i++) begin
        s1_dg_r[i] <= m[i][i];
      end
      s1_d12_r <= MAG_W'(m[1][2]) - MAG_W'(m[2][1]);
      s1_d20_r <= MAG_W'(m[2][0]) - MAG_W'(m[0][2]);
      s1_d01_r <= MAG_W'(m[0][1]) - MAG_W'(m[1][0]);
      s1_s01_r <= MAG_W'(m[0][1]) + MAG_W'(m[1][0]);
      s1_s02_r <= MAG_W'(m[0][2]) + MAG_W'(m[2][0]);
      s1_s12_r <= MAG_W'(m[1][2]) + MAG_W'(m[2][1]);
    end
  end

  // stage 2: radicand and per-slot numerators
  logic signed [RADW:0] rad;
  logic                 degen_nxt;
  side_a_t              sa_nxt;
  logic [RADW-1:0]      rad_u;

  always_comb begin
    sa_nxt.num = '0;
    sa_nxt.slot = SLOT_W;
    rad = (RADW+1)'(s1_tr_r) + (RADW+1)'(ONE);
    if (s1_tr_r > 0) begin
      sa_nxt.slot = SLOT_W;
      sa_nxt.num[SLOT_X] = s1_d12_r;
      sa_nxt.num[SLOT_Y] = s1_d20_r;
      sa_nxt.num[SLOT_Z] = s1_d01_r;
    end else begin
      case (s1_piv_r)
        2'd1: begin
          rad = (RADW+1)'(s1_dg_r[1]) - (RADW+1)'(s1_dg_r[2]) - (RADW+1)'(s1_dg_r[0])
              + (RADW+1)'(ONE);
          sa_nxt.slot = SLOT_Y;
          sa_nxt.num[SLOT_W] = s1_d20_r;
          sa_nxt.num[SLOT_Z] = s1_s12_r;
          sa_nxt.num[SLOT_X] = s1_s01_r;
        end
        2'd2: begin
          rad = (RADW+1)'(s1_dg_r[2]) - (RADW+1)'(s1_dg_r[0]) - (RADW+1)'(s1_dg_r[1])
              + (RADW+1)'(ONE);
          sa_nxt.slot = SLOT_Z;
          sa_nxt.num[SLOT_W] = s1_d01_r;
          sa_nxt.num[SLOT_X] = s1_s02_r;
          sa_nxt.num[SLOT_Y] = s1_s12_r;
        end
        default: begin
          rad = (RADW+1)'(s1_dg_r[0]) - (RADW+1)'(s1_dg_r[1]) - (RADW+1)'(s1_dg_r[2])
              + (RADW+1)'(ONE);
          sa_nxt.slot = SLOT_X;
          sa_nxt.num[SLOT_W] = s1_d12_r;
          sa_nxt.num[SLOT_Y] = s1_s01_r;
          sa_nxt.num[SLOT_Z] = s1_s02_r;
        end
      endcase
    end
    degen_nxt    = (rad <= 0);
    sa_nxt.degen = degen_nxt;
    // a degenerate radicand is replaced so the divider never sees zero
    rad_u = degen_nxt ? RADW'(1) : rad[RADW-1:0];
  end

  logic          s2_vld_r;
  logic [VW-1:0] s2_v_r;
  side_a_t       s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ce) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_v_r    <= VW'(rad_u) << FRAC_BITS;
      s2_side_r <= sa_nxt;
    end
  end

  // square root with side data delayed alongside
  logic [RTW-1:0] root;
  logic           sa_vld_r  [RTW];
  side_a_t        sa_side_r [RTW];

  rmq_sqrt #(.VW(VW)) u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .v    (s2_v_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RTW; i++) sa_vld_r[i] <= 1'b0;
    end else if (ce) begin
      sa_vld_r[0] <= s2_vld_r;
      for (int i = 1; i < RTW; i++) sa_vld_r[i] <= sa_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sa_side_r[0] <= s2_side_r;
      for (int i = 1; i < RTW; i++) sa_side_r[i] <= sa_side_r[i-1];
    end
  end

  // stage 3: rounded dividends, n = |num| * 2^F + root over 2 * root
  side_a_t              sa_end;
  logic [3:0][NW-1:0]   n_nxt;
  logic [3:0]           neg_nxt;
  logic [RTW:0]         half_sum;
  logic [MAG_W-1:0]     mag;

  assign sa_end   = sa_side_r[RTW-1];
  assign half_sum = (RTW+1)'(root) + (RTW+1)'(1);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg_nxt[k] = sa_end.num[k][MAG_W-1];
      mag        = neg_nxt[k] ? (MAG_W'(0) - sa_end.num[k]) : sa_end.num[k];
      n_nxt[k]   = (NW'(mag) << FRAC_BITS) + NW'(root);
    end
  end

  logic               s3_vld_r;
  logic [3:0][NW-1:0] s3_n_r;
  logic [DW-1:0]      s3_den_r;
  side_b_t            s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s3_vld_r <= sa_vld_r[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_n_r          <= n_nxt;
      s3_den_r        <= {root, 1'b0};
      s3_side_r.slot  <= sa_end.slot;
      s3_side_r.degen <= sa_end.degen;
      s3_side_r.neg   <= neg_nxt;
      s3_side_r.half  <= half_sum[RTW:1];
    end
  end

  // dividers, one per output slot
  logic [3:0][NW-1:0] quo;
  logic               sb_vld_r  [NW];
  side_b_t            sb_side_r [NW];

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_div
      rmq_div #(.NW(NW), .DW(DW)) u_div (
        .clk (clk),
        .ce  (ce),
        .n   (s3_n_r[g]),
        .d   (s3_den_r),
        .q   (quo[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) sb_vld_r[i] <= 1'b0;
    end else if (ce) begin
      sb_vld_r[0] <= s3_vld_r;
      for (int i = 1; i < NW; i++) sb_vld_r[i] <= sb_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_side_r[0] <= s3_side_r;
      for (int i = 1; i < NW; i++) sb_side_r[i] <= sb_side_r[i-1];
    end
  end

  // output stage: pick rounded half root or quotient, saturate, apply sign, zero if degenerate
  side_b_t              sb_end;
  logic [3:0][ELEM_W-1:0] comp_nxt;
  logic [NW-1:0]        cmag;
  logic [ELEM_W-1:0]    smag;

  assign sb_end = sb_side_r[NW-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (sb_end.slot == slot_t'(k)) begin
        cmag = NW'(sb_end.half);
      end else begin
        cmag = quo[k];
      end
      smag = (cmag > NW'(LIM)) ? ELEM_W'(LIM) : cmag[ELEM_W-1:0];
      if (sb_end.degen) begin
        comp_nxt[k] = '0;
      end else if (sb_end.slot != slot_t'(k) && sb_end.neg[k]) begin
        comp_nxt[k] = ELEM_W'(0) - smag;
      end else begin
        comp_nxt[k] = smag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (ce) begin
      out_tvalid <= sb_vld_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata <= comp_nxt;
      out_tuser <= sb_end.degen;
    end
  end

endmodule

`default_nettype wire

// File: sv/rmq_sqrt.sv
// pipelined integer square root, one result bit per register stage
// no dependencies; advances when ce is high
`default_nettype none

module rmq_sqrt #(
  parameter int VW = 34
) (
  input  wire logic            clk,
  input  wire logic            ce,
  input  wire logic [VW-1:0]   v,
  output logic      [VW/2-1:0] root
);

  localparam int RTW = VW / 2;

  logic [VW-1:0]  v_r   [RTW];
  logic [RTW-1:0] rt_r  [RTW];
  logic [RTW+1:0] rem_r [RTW];

  genvar s;
  generate
    for (s = 0; s < RTW; s++) begin : g_stg
      logic [VW-1:0]  v_in;
      logic [RTW-1:0] rt_in;
      logic [RTW+1:0] rem_in;
      logic [RTW+1:0] rem_sh;
      logic [RTW+1:0] trial;

      if (s == 0) begin : g_first
        assign v_in   = v;
        assign rt_in  = '0;
        assign rem_in = '0;
      end else begin : g_next
        assign v_in   = v_r[s-1];
        assign rt_in  = rt_r[s-1];
        assign rem_in = rem_r[s-1];
      end

      // bring down the next pair of radicand bits
      assign rem_sh = {rem_in[RTW-1:0], v_in[VW-1-2*s -: 2]};
      assign trial  = {rt_in, 2'b01};

      always_ff @(posedge clk) begin
        if (ce) begin
          v_r[s] <= v_in;
          if (rem_sh >= trial) begin
            rem_r[s] <= rem_sh - trial;
            rt_r[s]  <= {rt_in[RTW-2:0], 1'b1};
          end else begin
            rem_r[s] <= rem_sh;
            rt_r[s]  <= {rt_in[RTW-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root = rt_r[RTW-1];

endmodule

`default_nettype wire

// File: sv/rmq_div.sv
// pipelined restoring divider, one quotient bit per register stage
// no dependencies; advances when ce is high
`default_nettype none

module rmq_div #(
  parameter int NW = 32,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          ce,
  input  wire logic [NW-1:0] n,
  input  wire logic [DW-1:0] d,
  output logic      [NW-1:0] q
);

  logic [NW-1:0] n_r   [NW];
  logic [DW-1:0] d_r   [NW];
  logic [NW-1:0] q_r   [NW];
  logic [DW-1:0] rem_r [NW];

  genvar s;
  generate
    for (s = 0; s < NW; s++) begin : g_stg
      logic [NW-1:0] n_in;
      logic [DW-1:0] d_in;
      logic [NW-1:0] q_in;
      logic [DW-1:0] rem_in;
      logic [DW:0]   rem_sh;
      logic [DW:0]   diff;

      if (s == 0) begin : g_first
        assign n_in   = n;
        assign d_in   = d;
        assign q_in   = '0;
        assign rem_in = '0;
      end else begin : g_next
        assign n_in   = n_r[s-1];
        assign d_in   = d_r[s-1];
        assign q_in   = q_r[s-1];
        assign rem_in = rem_r[s-1];
      end

      assign rem_sh = {rem_in, n_in[NW-1-s]};
      assign diff   = rem_sh - {1'b0, d_in};

      always_ff @(posedge clk) begin
        if (ce) begin
          n_r[s] <= n_in;
          d_r[s] <= d_in;
          if (rem_sh >= {1'b0, d_in}) begin
            rem_r[s] <= diff[DW-1:0];
            q_r[s]   <= {q_in[NW-2:0], 1'b1};
          end else begin
            rem_r[s] <= rem_sh[DW-1:0];
            q_r[s]   <= {q_in[NW-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign q = q_r[NW-1];

endmodule

`default_nettype wire
